@@ src/lmvo_pkg.sv @@
// ----------------------------------------------------------------------------
// lmvo_pkg
// Shared constants, codes, command/status types and the sine table function
// of the voice oscillator.
// ----------------------------------------------------------------------------
package lmvo_pkg;

	// Parameter defaults
	localparam int PHASE_BITS_DEF      = 24;
	localparam int SINE_TABLE_BITS_DEF = 10;
	localparam int RELEASE_TICKS_DEF   = 13230;
	localparam int RATE_MOD_STEP_DEF   = 38;
	localparam int RATE_MOD_DEPTH_DEF  = 190;

	// Fixed widths
	localparam int CNT_W   = 24;
	localparam int SAMP_W  = 16;
	localparam int SINE_W  = 17;
	localparam int MOD_W   = 18;
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 18;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int QUO_W   = 16;
	localparam int DCNT_W  = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CNT_W-1:0]  CNT_MAX    = 24'hFFFFFF;
	localparam logic [15:0]       Q15_ONE    = 16'd32768;
	localparam logic [15:0]       LFSR_RESET = 16'hACE1;
	localparam logic [15:0]       LFSR_TAPS  = 16'hB400;

	// Waveform codes
	typedef enum logic [2:0] {
		WAVE_SINE    = 3'd0,
		WAVE_SQUARE  = 3'd1,
		WAVE_SAW     = 3'd2,
		WAVE_TRI     = 3'd3,
		WAVE_PULSE   = 3'd4,
		WAVE_NOISE   = 3'd5,
		WAVE_SINE_SQ = 3'd6
	} wave_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WAVE_SELECT   = 3'd0,
		REG_TONE_STEP     = 3'd1,
		REG_AMPLITUDE     = 3'd2,
		REG_LFO_STEP      = 3'd3,
		REG_LFO_DEPTH     = 3'd4,
		REG_ATTACK_TICKS  = 3'd5,
		REG_DECAY_TICKS   = 3'd6,
		REG_SUSTAIN_LEVEL = 3'd7
	} reg_idx_t;

	// Sine table read selects
	typedef enum logic [1:0] {
		LUT_RATE = 2'd0,
		LUT_LFO  = 2'd1,
		LUT_TONE = 2'd2,
		LUT_HALF = 2'd3
	} lut_sel_t;

	// Shared multiplier operand selects
	typedef enum logic [2:0] {
		MUL_ENV   = 3'd0,
		MUL_RMOD  = 3'd1,
		MUL_SQ    = 3'd2,
		MUL_DEPTH = 3'd3,
		MUL_DEV   = 3'd4,
		MUL_SMP   = 3'd5
	} mul_sel_t;

	typedef struct packed {
		logic     start;
		lut_sel_t lut_sel;
		logic     lut_en;
		mul_sel_t mul_sel;
		logic     mul_en;
		logic     env_setup;
		logic     div_load;
		logic     cap_lfo;
		logic     cap_tone;
		logic     cap_sq;
		logic     cap_dev;
		logic     finish;
	} lmvo_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} lmvo_stat_t;

	// Sine table entry for a full-cycle index, quarter-wave polynomial
	function automatic logic signed [SINE_W-1:0] sine_entry(input int unsigned idx,
		input int unsigned tbits);
		longint unsigned quarter, quad, r, x, x2, t, y;
		int unsigned     qbits;
		qbits   = tbits - 2;
		quarter = 64'd1 << qbits;
		quad    = (longint'(idx) >> qbits) & 64'd3;
		r       = longint'(idx) & (quarter - 64'd1);
		if (quad[0])
			r = quarter - r;
		x  = r << (17 - tbits);
		x2 = (x * x) >> 15;
		t  = (x2 * 64'd2320) >> 15;
		t  = 64'd21024 - t;
		t  = (x2 * t) >> 15;
		t  = 64'd51472 - t;
		y  = (x * t) >> 15;
		if (quad[1])
			return -$signed(SINE_W'(y));
		return $signed(SINE_W'(y));
	endfunction

endpackage

@@ src/lmvo_if.sv @@
// ----------------------------------------------------------------------------
// lmvo_if
// Valid/ready channels of the voice oscillator: tick in, sample out, config.
// ----------------------------------------------------------------------------
interface lmvo_tick_if import lmvo_pkg::*; ();
	logic valid;
	logic ready;
	logic gate;
	logic restart;
	modport source (output valid, input ready, output gate, output restart);
	modport sink (input valid, output ready, input gate, input restart);
endinterface

interface lmvo_result_if import lmvo_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [SAMP_W-1:0] sample_out;
	logic [15:0]              env_level;
	modport source (output valid, input ready, output sample_out, output env_level);
	modport sink (input valid, output ready, input sample_out, input env_level);
endinterface

interface lmvo_cfg_if import lmvo_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, input ready, output index, output data);
	modport sink (input valid, output ready, input index, input data);
endinterface

@@ src/lmvo_ctrl.sv @@
// ----------------------------------------------------------------------------
// lmvo_ctrl
// Sequencer for one tick: envelope divide, sine reads and multiplier turns.
// ----------------------------------------------------------------------------
module lmvo_ctrl import lmvo_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       tick_valid,
	output logic       tick_ready,
	input  lmvo_stat_t stat,
	output lmvo_cmd_t  cmd
);

	typedef enum logic [11:0] {
		ST_IDLE      = 12'b0000_0000_0001,
		ST_ENV_MUL   = 12'b0000_0000_0010,
		ST_DIV_LOAD  = 12'b0000_0000_0100,
		ST_RMOD      = 12'b0000_0000_1000,
		ST_TONE      = 12'b0000_0001_0000,
		ST_SQ_MUL    = 12'b0000_0010_0000,
		ST_SQ_CAP    = 12'b0000_0100_0000,
		ST_WAIT_DIV  = 12'b0000_1000_0000,
		ST_DEPTH_MUL = 12'b0001_0000_0000,
		ST_DEV_MUL   = 12'b0010_0000_0000,
		ST_SMP_MUL   = 12'b0100_0000_0000,
		ST_OUTPUT    = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;

	assign tick_ready = (state_q == ST_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (tick_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_ENV_MUL;
				end
			end
			ST_ENV_MUL: begin
				cmd.env_setup = 1'b1;
				cmd.mul_sel   = MUL_ENV;
				cmd.mul_en    = 1'b1;
				cmd.lut_sel   = LUT_RATE;
				cmd.lut_en    = 1'b1;
				state_d       = ST_DIV_LOAD;
			end
			ST_DIV_LOAD: begin
				cmd.div_load = 1'b1;
				cmd.mul_sel  = MUL_RMOD;
				cmd.mul_en   = 1'b1;
				cmd.lut_sel  = LUT_LFO;
				cmd.lut_en   = 1'b1;
				state_d      = ST_RMOD;
			end
			ST_RMOD: begin
				cmd.cap_lfo = 1'b1;
				cmd.lut_sel = LUT_TONE;
				cmd.lut_en  = 1'b1;
				state_d     = ST_TONE;
			end
			ST_TONE: begin
				cmd.cap_tone = 1'b1;
				cmd.lut_sel  = LUT_HALF;
				cmd.lut_en   = 1'b1;
				state_d      = ST_SQ_MUL;
			end
			ST_SQ_MUL: begin
				cmd.mul_sel = MUL_SQ;
				cmd.mul_en  = 1'b1;
				state_d     = ST_SQ_CAP;
			end
			ST_SQ_CAP: begin
				cmd.cap_sq = 1'b1;
				state_d    = ST_WAIT_DIV;
			end
			ST_WAIT_DIV: begin
				if (stat.div_done)
					state_d = ST_DEPTH_MUL;
			end
			ST_DEPTH_MUL: begin
				cmd.mul_sel = MUL_DEPTH;
				cmd.mul_en  = 1'b1;
				state_d     = ST_DEV_MUL;
			end
			ST_DEV_MUL: begin
				cmd.mul_sel = MUL_DEV;
				cmd.mul_en  = 1'b1;
				state_d     = ST_SMP_MUL;
			end
			ST_SMP_MUL: begin
				cmd.cap_dev = 1'b1;
				cmd.mul_sel = MUL_SMP;
				cmd.mul_en  = 1'b1;
				state_d     = ST_OUTPUT;
			end
			ST_OUTPUT: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

@@ src/lmvo_dp.sv @@
// ----------------------------------------------------------------------------
// lmvo_dp
// Datapath: config registers, phase accumulators, envelope counters, LFSR,
// sine table, shared multiplier, restoring divider and output register.
// ----------------------------------------------------------------------------
module lmvo_dp import lmvo_pkg::*; #(
	parameter int PHASE_BITS      = PHASE_BITS_DEF,
	parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
	parameter int RELEASE_TICKS   = RELEASE_TICKS_DEF,
	parameter int RATE_MOD_STEP   = RATE_MOD_STEP_DEF,
	parameter int RATE_MOD_DEPTH  = RATE_MOD_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  lmvo_cmd_t    cmd,
	output lmvo_stat_t   stat,
	input  logic         gate,
	input  logic         restart,
	lmvo_cfg_if.sink     cfg,
	lmvo_result_if.source result
);

	localparam int PB     = PHASE_BITS;
	localparam int TB     = SINE_TABLE_BITS;
	localparam int LUT_N  = 1 << TB;
	localparam logic [CNT_W-1:0]   REL_TICKS = CNT_W'(RELEASE_TICKS);
	localparam logic [MUL_A_W-1:0] RM_INC    = MUL_A_W'(RATE_MOD_STEP);
	localparam logic [15:0]        RM_DEPTH  = 16'(RATE_MOD_DEPTH);
	localparam logic signed [SINE_W-1:0] W_POS = 17'sd32768;
	localparam logic signed [SINE_W-1:0] W_NEG = -17'sd32768;

	// Configuration registers
	logic [2:0]       wave_q;
	logic [CNT_W-1:0] tone_step_q, lfo_step_q, attack_q, decay_q;
	logic [15:0]      amp_q, depth_q, sustain_q;

	// Tick state
	logic [PB-1:0]    tone_phase_q, lfo_phase_q, rm_phase_q;
	logic [CNT_W-1:0] held_q, rel_q;
	logic [15:0]      noise_q;
	logic             gate_q;

	// Work registers
	logic signed [SINE_W-1:0] sine_q, lfo_s_q, tone_s_q, sq_q;
	logic signed [MOD_W-1:0]  rmod_q, dev_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [CNT_W-1:0]         divisor_q, rem_q;
	logic [QUO_W-1:0]         dvd_lo_q, quo_q;
	logic [DCNT_W-1:0]        div_cnt_q;
	logic                     env_sub_q;

	// Output register
	logic                     out_valid_q;
	logic signed [SAMP_W-1:0] sample_q;
	logic [15:0]              env_out_q;

	assign cfg.ready         = 1'b1;
	assign result.valid      = out_valid_q;
	assign result.sample_out = sample_q;
	assign result.env_level  = env_out_q;
	assign stat.out_free     = !out_valid_q || result.ready;
	assign stat.div_done     = (div_cnt_q == '0);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q      <= WAVE_SINE;
			tone_step_q <= '0;
			amp_q       <= 16'd32768;
			lfo_step_q  <= 24'd456;
			depth_q     <= 16'd38;
			attack_q    <= 24'd4410;
			decay_q     <= 24'd8820;
			sustain_q   <= 16'd22938;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_WAVE_SELECT:   wave_q      <= cfg.data[2:0];
				REG_TONE_STEP:     tone_step_q <= cfg.data;
				REG_AMPLITUDE:     amp_q       <= cfg.data[15:0];
				REG_LFO_STEP:      lfo_step_q  <= cfg.data;
				REG_LFO_DEPTH:     depth_q     <= cfg.data[15:0];
				REG_ATTACK_TICKS:  attack_q    <= cfg.data;
				REG_DECAY_TICKS:   decay_q     <= cfg.data;
				REG_SUSTAIN_LEVEL: sustain_q   <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	// Sine table, built at elaboration
	logic signed [SINE_W-1:0] sine_lut [LUT_N];
	for (genvar i = 0; i < LUT_N; i++) begin : g_lut
		assign sine_lut[i] = sine_entry(i, TB);
	end

	logic [TB-1:0] lut_idx;
	always_comb begin
		case (cmd.lut_sel)
			LUT_RATE: lut_idx = rm_phase_q[PB-1 -: TB];
			LUT_LFO:  lut_idx = lfo_phase_q[PB-1 -: TB];
			LUT_TONE: lut_idx = tone_phase_q[PB-1 -: TB];
			default:  lut_idx = {1'b0, tone_phase_q[PB-1 -: TB-1]};
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.lut_en)
			sine_q <= sine_lut[lut_idx];
	end

	// Envelope operands: dividend factors and divisor per segment
	logic [15:0]      sus;
	logic [CNT_W:0]   ad_sum;
	logic [CNT_W-1:0] env_a, env_div;
	logic [16:0]      env_b;
	logic             env_sub;
	always_comb begin
		sus     = (sustain_q > Q15_ONE) ? Q15_ONE : sustain_q;
		ad_sum  = {1'b0, attack_q} + {1'b0, decay_q};
		env_sub = 1'b0;
		if (gate_q) begin
			if (held_q < attack_q) begin
				env_a   = held_q;
				env_b   = 17'd32768;
				env_div = attack_q;
			end else if ({1'b0, held_q} < ad_sum) begin
				env_a   = held_q - attack_q;
				env_b   = 17'd32768 - {1'b0, sus};
				env_div = decay_q;
				env_sub = 1'b1;
			end else begin
				env_a   = CNT_W'(sus);
				env_b   = 17'd1;
				env_div = CNT_W'(1);
			end
		end else if (rel_q < REL_TICKS) begin
			env_a   = REL_TICKS - rel_q;
			env_b   = {1'b0, sus};
			env_div = REL_TICKS;
		end else begin
			env_a   = '0;
			env_b   = 17'd1;
			env_div = CNT_W'(1);
		end
	end

	// Decay counts down from unity
	logic [15:0] env_val;
	assign env_val = env_sub_q ? (Q15_ONE - quo_q) : quo_q;

	// Waveform select: shapes from the tone phase, noise from the LFSR
	logic [15:0]              u;
	logic signed [SINE_W-1:0] saw_w, mag, noise_w, w;
	logic signed [SINE_W:0]   tri_w;
	always_comb begin
		u       = tone_phase_q[PB-1 -: 16];
		saw_w   = SINE_W'($signed(u));
		mag     = (saw_w < 0) ? -saw_w : saw_w;
		tri_w   = (18'(mag) <<< 1) - 18'sd32768;
		noise_w = $signed({1'b0, noise_q}) - W_POS;
		case (wave_q)
			WAVE_SINE:    w = tone_s_q;
			WAVE_SQUARE:  w = (tone_s_q > 0) ? W_POS : W_NEG;
			WAVE_SAW:     w = saw_w;
			WAVE_TRI:     w = tri_w[SINE_W-1:0];
			WAVE_PULSE:   w = u[15] ? W_NEG : W_POS;
			WAVE_NOISE:   w = noise_w;
			WAVE_SINE_SQ: w = sq_q;
			default:      w = '0;
		endcase
	end

	// Shared multiplier
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	always_comb begin
		case (cmd.mul_sel)
			MUL_ENV: begin
				mul_a = $signed({10'd0, env_a});
				mul_b = $signed({1'b0, env_b});
			end
			MUL_RMOD: begin
				mul_a = MUL_A_W'(sine_q);
				mul_b = $signed({2'b0, RM_DEPTH});
			end
			MUL_SQ: begin
				mul_a = MUL_A_W'(sine_q);
				mul_b = MUL_B_W'(sine_q);
			end
			MUL_DEPTH: begin
				mul_a = $signed({18'd0, depth_q});
				mul_b = $signed({2'b0, env_val});
			end
			MUL_DEV: begin
				mul_a = prod_q[MUL_A_W-1:0];
				mul_b = MUL_B_W'(lfo_s_q);
			end
			MUL_SMP: begin
				mul_a = MUL_A_W'(w);
				mul_b = $signed({2'b0, amp_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	logic signed [PROD_W-1:0] prod_sh15, prod_sh30;
	assign prod_sh15 = prod_q >>> 15;
	assign prod_sh30 = prod_q >>> 30;

	// Capture products and table reads
	always_ff @(posedge clk) begin
		if (cmd.mul_en)
			prod_q <= mul_p;
		if (cmd.env_setup) begin
			divisor_q <= env_div;
			env_sub_q <= env_sub;
		end
		if (cmd.cap_lfo) begin
			rmod_q  <= prod_sh15[MOD_W-1:0];
			lfo_s_q <= sine_q;
		end
		if (cmd.cap_tone)
			tone_s_q <= sine_q;
		if (cmd.cap_sq)
			sq_q <= prod_sh15[SINE_W-1:0];
		if (cmd.cap_dev)
			dev_q <= prod_sh30[MOD_W-1:0];
	end

	// Restoring divider, one quotient bit per cycle
	logic [CNT_W:0] trial;
	logic           fits;
	assign trial = {rem_q, dvd_lo_q[QUO_W-1]};
	assign fits  = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			div_cnt_q <= '0;
		else if (cmd.div_load)
			div_cnt_q <= DCNT_W'(QUO_W);
		else if (div_cnt_q != '0)
			div_cnt_q <= div_cnt_q - 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q    <= prod_q[QUO_W + CNT_W - 1:QUO_W];
			dvd_lo_q <= prod_q[QUO_W-1:0];
		end else if (div_cnt_q != '0) begin
			rem_q    <= fits ? CNT_W'(trial - {1'b0, divisor_q}) : trial[CNT_W-1:0];
			dvd_lo_q <= {dvd_lo_q[QUO_W-2:0], 1'b0};
			quo_q    <= {quo_q[QUO_W-2:0], fits};
		end
	end

	// Phase advance amounts
	logic signed [MUL_A_W-1:0] tone_inc, lfo_inc;
	assign tone_inc = $signed({10'd0, tone_step_q}) + MUL_A_W'(dev_q);
	assign lfo_inc  = $signed({10'd0, lfo_step_q}) + MUL_A_W'(rmod_q);

	logic [15:0] noise_next;
	assign noise_next = {1'b0, noise_q[15:1]} ^ (noise_q[0] ? LFSR_TAPS : 16'd0);

	// Clear on restart at accept, advance after the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_phase_q <= '0;
			lfo_phase_q  <= '0;
			rm_phase_q   <= '0;
			held_q       <= '0;
			rel_q        <= '0;
			noise_q      <= LFSR_RESET;
			gate_q       <= 1'b0;
		end else if (cmd.start) begin
			gate_q  <= gate;
			noise_q <= noise_next;
			if (restart) begin
				tone_phase_q <= '0;
				lfo_phase_q  <= '0;
				rm_phase_q   <= '0;
				held_q       <= '0;
				rel_q        <= '0;
			end
		end else if (cmd.finish) begin
			tone_phase_q <= tone_phase_q + tone_inc[PB-1:0];
			lfo_phase_q  <= lfo_phase_q + lfo_inc[PB-1:0];
			rm_phase_q   <= rm_phase_q + RM_INC[PB-1:0];
			held_q       <= (held_q == CNT_MAX) ? CNT_MAX : held_q + 1'b1;
			rel_q        <= gate_q ? '0 : ((rel_q == CNT_MAX) ? CNT_MAX : rel_q + 1'b1);
		end
	end

	// Saturate and hold the result
	logic signed [SAMP_W-1:0] sample_sat;
	always_comb begin
		if (prod_sh15 > 52'sd32767)
			sample_sat = 16'sh7FFF;
		else if (prod_sh15 < -52'sd32768)
			sample_sat = 16'sh8000;
		else
			sample_sat = prod_sh15[SAMP_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.finish)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			sample_q  <= sample_sat;
			env_out_q <= env_val;
		end
	end

endmodule

@@ src/lfo_modulated_voice_oscillator.sv @@
// ----------------------------------------------------------------------------
// lfo_modulated_voice_oscillator
// Tone oscillator with LFO vibrato, LFO rate modulation and ADSR envelope.
// ----------------------------------------------------------------------------
// Flow: an accepted tick runs the envelope divide, sine reads and multiplies, then
// loads the output register once it is free; a new tick is taken only in idle.
// A finished sample waits in the output register while the next tick runs.
// Reset: asynchronous, active low; clears control, phases and counters, seeds the LFSR,
// and loads the configuration registers with their defaults.
module lfo_modulated_voice_oscillator import lmvo_pkg::*; #(
	parameter int PHASE_BITS      = PHASE_BITS_DEF,
	parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
	parameter int RELEASE_TICKS   = RELEASE_TICKS_DEF,
	parameter int RATE_MOD_STEP   = RATE_MOD_STEP_DEF,
	parameter int RATE_MOD_DEPTH  = RATE_MOD_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	lmvo_tick_if.sink     tick,
	lmvo_result_if.source result,
	lmvo_cfg_if.sink      cfg
);

	lmvo_cmd_t  cmd;
	lmvo_stat_t stat;

	lmvo_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick.valid),
		.tick_ready (tick.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	lmvo_dp #(
		.PHASE_BITS      (PHASE_BITS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS),
		.RELEASE_TICKS   (RELEASE_TICKS),
		.RATE_MOD_STEP   (RATE_MOD_STEP),
		.RATE_MOD_DEPTH  (RATE_MOD_DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.gate    (tick.gate),
		.restart (tick.restart),
		.cfg     (cfg),
		.result  (result)
	);

`ifndef ASSERT_OFF
	// One tick at a time: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(tick.valid && tick.ready) |=> !tick.ready)
		else $error("tick accepted while previous tick in flight");

	// Envelope never exceeds unity
	a_env_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.env_level <= Q15_ONE))
		else $error("env_level above unity");

	// A new result appears only at the end of a tick's work
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (stat.div_done && !tick.ready))
		else $error("result loaded outside tick processing");
`endif

endmodule
